// File: hw/rtl/average_pooling_window_unit_macros.svh
// Assertion macros used by the pooling unit checker.
`ifndef AVERAGE_POOLING_WINDOW_UNIT_MACROS_SVH
`define AVERAGE_POOLING_WINDOW_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define APW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define APW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/apw_pkg.sv
// Shared types and constants of the average pooling window unit.
package apw_pkg;

  localparam int ROW_W       = 8;
  localparam int COL_W       = 8;
  localparam int IN_SAMPLE_W = 16;
  localparam int AVG_W       = 16;
  localparam int CNT_W       = 8;
  localparam int COORD_W     = 13;  // signed window coordinate, row*stride - pad + offset
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_HEIGHT         = 3'd0,
    REG_IN_WIDTH          = 3'd1,
    REG_KERNEL_H          = 3'd2,
    REG_KERNEL_W          = 3'd3,
    REG_STRIDE_H          = 3'd4,
    REG_STRIDE_W          = 3'd5,
    REG_PAD_BEGIN         = 3'd6,
    REG_COUNT_INCLUDE_PAD = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    REQ_STORE   = 1'b0,
    REQ_AVERAGE = 1'b1
  } req_type_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_t;

  localparam logic [8:0] RST_IN_HEIGHT = 9'd256;
  localparam logic [8:0] RST_IN_WIDTH  = 9'd256;
  localparam logic [3:0] RST_KERNEL    = 4'd2;
  localparam logic [3:0] RST_STRIDE    = 4'd2;
  localparam logic [7:0] RST_PAD       = 8'd0;
  localparam logic       RST_CIP       = 1'b0;

endpackage

// File: hw/rtl/apw_ifs.sv
// Channel interfaces of the average pooling window unit.
interface apw_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   req_type;
  logic        [apw_pkg::ROW_W-1:0]       row;
  logic        [apw_pkg::COL_W-1:0]       col;
  logic signed [apw_pkg::IN_SAMPLE_W-1:0] sample;
  modport source (output valid, req_type, row, col, sample, input ready);
  modport sink   (input valid, req_type, row, col, sample, output ready);
endinterface

interface apw_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [apw_pkg::AVG_W-1:0] average;
  logic        [apw_pkg::CNT_W-1:0] elements_counted;
  logic                             divisor_zero;
  modport source (output valid, average, elements_counted, divisor_zero, input ready);
  modport sink   (input valid, average, elements_counted, divisor_zero, output ready);
endinterface

interface apw_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [apw_pkg::CFG_IDX_W-1:0]     index;
  logic [apw_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/average_pooling_window_unit.sv
// Average pooling window unit: one stored plane of samples, windowed averages on request.
// A store request writes the sample RAM directly. An average request walks the
// kernel_h x kernel_w window one position per cycle through the single read port of
// the sample RAM (out-of-plane positions are not read but still take their scan step),
// then runs a one-bit-per-cycle divide over SAMPLE_BITS+8 quotient bits. The input is
// ready again once the result is registered, also while that result waits to be taken.
// The sample RAM holds MAX_HEIGHT x MAX_WIDTH entries with no reset; averaging over a
// position that was never stored gives an undefined result.
module average_pooling_window_unit #(
  parameter int MAX_HEIGHT  = 256,
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_KERNEL  = 15,
  parameter int SAMPLE_BITS = 16
) (
  input logic         clk,
  input logic         rst_n,
  apw_in_if.sink      in_ch,
  apw_out_if.source   out_ch,
  apw_cfg_if.sink     cfg_ch
);

  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = 2 ** AW;
  localparam int KB    = $clog2(MAX_KERNEL + 1);
  localparam int SUM_W = SAMPLE_BITS + apw_pkg::CNT_W;
  localparam int XW    = apw_pkg::COORD_W;

  // configuration
  logic [8:0] in_height_r, in_width_r;
  logic [3:0] kernel_h_r, kernel_w_r, stride_h_r, stride_w_r;
  logic [7:0] pad_begin_r;
  logic       cip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_height_r <= apw_pkg::RST_IN_HEIGHT;
      in_width_r  <= apw_pkg::RST_IN_WIDTH;
      kernel_h_r  <= apw_pkg::RST_KERNEL;
      kernel_w_r  <= apw_pkg::RST_KERNEL;
      stride_h_r  <= apw_pkg::RST_STRIDE;
      stride_w_r  <= apw_pkg::RST_STRIDE;
      pad_begin_r <= apw_pkg::RST_PAD;
      cip_r       <= apw_pkg::RST_CIP;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (apw_pkg::cfg_reg_t'(cfg_ch.index))
        apw_pkg::REG_IN_HEIGHT:         in_height_r <= cfg_ch.data;
        apw_pkg::REG_IN_WIDTH:          in_width_r  <= cfg_ch.data;
        apw_pkg::REG_KERNEL_H:          kernel_h_r  <= cfg_ch.data[3:0];
        apw_pkg::REG_KERNEL_W:          kernel_w_r  <= cfg_ch.data[3:0];
        apw_pkg::REG_STRIDE_H:          stride_h_r  <= cfg_ch.data[3:0];
        apw_pkg::REG_STRIDE_W:          stride_w_r  <= cfg_ch.data[3:0];
        apw_pkg::REG_PAD_BEGIN:         pad_begin_r <= cfg_ch.data[7:0];
        apw_pkg::REG_COUNT_INCLUDE_PAD: cip_r       <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // saturated sizes
  logic [XW-1:0]   h_eff, w_eff;
  logic [6:0]      kh_wide, kw_wide;
  logic [KB-1:0]   kh_eff, kw_eff;
  logic [2*KB-1:0] area_w;
  logic            kdim_ok;

  always_comb begin
    h_eff   = (XW'(in_height_r) > XW'(MAX_HEIGHT)) ? XW'(MAX_HEIGHT) : XW'(in_height_r);
    w_eff   = (XW'(in_width_r) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(in_width_r);
    kh_wide = {3'b000, kernel_h_r};
    kw_wide = {3'b000, kernel_w_r};
    kh_eff  = (kh_wide > 7'(MAX_KERNEL)) ? KB'(MAX_KERNEL) : KB'(kh_wide);
    kw_eff  = (kw_wide > 7'(MAX_KERNEL)) ? KB'(MAX_KERNEL) : KB'(kw_wide);
    area_w  = kh_eff * kw_eff;
    kdim_ok = (kh_eff != '0) && (kw_eff != '0);
  end

  // sequencer state
  apw_pkg::state_t state_r, state_nxt;
  logic [KB-1:0]   i_r, j_r;
  logic [XW-1:0]   r0_r, c0_r;
  logic            rd_pend_r;
  logic signed [SUM_W-1:0]      sum_r;
  logic [apw_pkg::CNT_W-1:0]    count_r;
  logic signed [apw_pkg::AVG_W-1:0] avg_r;
  logic            zero_r;

  logic            out_valid_r;
  logic signed [apw_pkg::AVG_W-1:0] out_avg_r;
  logic [apw_pkg::CNT_W-1:0]        out_cnt_r;
  logic            out_zero_r;

  // input side
  logic               in_acc, st_we;
  logic [11:0]        row_scaled, col_scaled;
  logic [XW-1:0]      r0_nxt, c0_nxt;
  logic [SAMPLE_BITS-1:0] st_data;
  logic [AW-1:0]      st_addr;

  assign in_ch.ready = (state_r == apw_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    row_scaled = in_ch.row * stride_h_r;
    col_scaled = in_ch.col * stride_w_r;
    r0_nxt     = XW'(row_scaled) - XW'(pad_begin_r[7:4]);
    c0_nxt     = XW'(col_scaled) - XW'(pad_begin_r[3:0]);
    st_we      = in_acc && (apw_pkg::req_type_t'(in_ch.req_type) == apw_pkg::REQ_STORE) &&
                 (XW'(in_ch.row) < h_eff) && (XW'(in_ch.col) < w_eff);
    st_data    = SAMPLE_BITS'(in_ch.sample);
    st_addr    = {RW'(in_ch.row), CW'(in_ch.col)};
  end

  // window scan
  logic [XW-1:0] r_cur, c_cur;
  logic          pos_ok, scan_last, row_end, rd_en;
  logic [AW-1:0] rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;

  always_comb begin
    r_cur     = r0_r + XW'(i_r);
    c_cur     = c0_r + XW'(j_r);
    pos_ok    = kdim_ok && !r_cur[XW-1] && (r_cur < h_eff) &&
                !c_cur[XW-1] && (c_cur < w_eff);
    row_end   = (j_r == KB'(kw_eff - 1'b1));
    scan_last = !kdim_ok || (row_end && (i_r == KB'(kh_eff - 1'b1)));
    rd_en     = (state_r == apw_pkg::ST_SCAN) && pos_ok;
    rd_addr   = {RW'(r_cur), CW'(c_cur)};
  end

  apw_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_plane (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_addr),
    .wdata (st_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // divide
  logic [apw_pkg::CNT_W-1:0] divisor;
  logic                      div_start, div_done;
  logic signed [SUM_W-1:0]   div_quo;

  assign divisor   = cip_r ? apw_pkg::CNT_W'(area_w) : count_r;
  assign div_start = (state_r == apw_pkg::ST_PREP) && (divisor != '0);

  apw_div #(
    .W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  logic out_load;

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    unique case (state_r)
      apw_pkg::ST_IDLE: begin
        if (in_acc && (apw_pkg::req_type_t'(in_ch.req_type) == apw_pkg::REQ_AVERAGE)) begin
          state_nxt = apw_pkg::ST_SCAN;
        end
      end
      apw_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = apw_pkg::ST_DRAIN;
        end
      end
      apw_pkg::ST_DRAIN: state_nxt = apw_pkg::ST_PREP;
      apw_pkg::ST_PREP: begin
        state_nxt = (divisor != '0) ? apw_pkg::ST_DIV : apw_pkg::ST_FIN;
      end
      apw_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = apw_pkg::ST_FIN;
        end
      end
      apw_pkg::ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = apw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = apw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apw_pkg::ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_en;
      out_valid_r <= out_load || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == apw_pkg::ST_IDLE) begin
      i_r     <= '0;
      j_r     <= '0;
      r0_r    <= r0_nxt;
      c0_r    <= c0_nxt;
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      if (state_r == apw_pkg::ST_SCAN) begin
        // advance along the row, wrap to the next one at its end
        if (row_end) begin
          j_r <= '0;
          i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
        if (pos_ok) begin
          count_r <= count_r + 1'b1;
        end
      end
      if (rd_pend_r) begin
        sum_r <= sum_r + SUM_W'($signed(rd_data));
      end
    end
    if (state_r == apw_pkg::ST_PREP && divisor == '0) begin
      avg_r  <= '0;
      zero_r <= 1'b1;
    end else if (state_r == apw_pkg::ST_DIV && div_done) begin
      avg_r  <= div_quo[apw_pkg::AVG_W-1:0];
      zero_r <= 1'b0;
    end
    if (out_load) begin
      out_avg_r  <= avg_r;
      out_cnt_r  <= count_r;
      out_zero_r <= zero_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.average          = out_avg_r;
  assign out_ch.elements_counted = out_cnt_r;
  assign out_ch.divisor_zero     = out_zero_r;

endmodule

// File: hw/rtl/apw_ram.sv
// Generic simple dual-port RAM with registered read data.
module apw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/apw_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module apw_div #(
  parameter int W = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [W-1:0]             dividend,
  input  logic [apw_pkg::CNT_W-1:0]       divisor,
  output logic                            done,
  output logic signed [W-1:0]             quotient
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic                          busy_r;
  logic                          done_r;
  logic [CW-1:0]                 cnt_r;
  logic [apw_pkg::CNT_W-1:0]     rem_r, rem_nxt;
  logic [apw_pkg::CNT_W-1:0]     dvs_r;
  logic [W-1:0]                  quo_r, quo_nxt;
  logic                          neg_r;
  logic [apw_pkg::CNT_W:0]       trial;
  logic                          qbit;

  // Remainder stays below the divisor, so the shifted trial fits one extra bit.
  always_comb begin
    trial = {rem_r, quo_r[W-1]};
    qbit  = (trial >= {1'b0, dvs_r});
    rem_nxt = qbit ? apw_pkg::CNT_W'(trial - {1'b0, dvs_r}) : trial[apw_pkg::CNT_W-1:0];
    quo_nxt = {quo_r[W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[W-1];
      quo_r <= dividend[W-1] ? W'(-dividend) : W'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? $signed(W'(-quo_r)) : $signed(quo_r);

endmodule

// File: hw/rtl/apw_checker.sv
// Port-level checker of the average pooling window unit and its bind.
`include "average_pooling_window_unit_macros.svh"

module apw_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_req_type,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [apw_pkg::AVG_W-1:0]        out_average,
  input logic [apw_pkg::CNT_W-1:0]        out_elements_counted,
  input logic                             out_divisor_zero
);

  logic in_avg_acc, in_st_acc, out_stall;

  assign in_avg_acc = in_valid && in_ready && (in_req_type == apw_pkg::REQ_AVERAGE);
  assign in_st_acc  = in_valid && in_ready && (in_req_type == apw_pkg::REQ_STORE);
  assign out_stall  = out_valid && !out_ready;

  `APW_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_average) && $stable(out_elements_counted) && $stable(out_divisor_zero), "result changed while stalled")
  `APW_ASSERT_NEXT(a_busy_after_avg, in_avg_acc, !in_ready, "input taken during window scan")
  `APW_ASSERT_NEXT(a_store_no_result, in_st_acc && !out_valid, !out_valid, "store produced a result")
  `APW_ASSERT_NOW(a_zero_avg, out_valid && out_divisor_zero, out_average == '0, "zero divisor with nonzero average")
  `APW_ASSERT_NOW(a_count_max, out_valid, out_elements_counted <= 8'd225, "window count above kernel area limit")

endmodule

bind average_pooling_window_unit apw_checker u_apw_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .in_req_type          (in_ch.req_type),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_average          (out_ch.average),
  .out_elements_counted (out_ch.elements_counted),
  .out_divisor_zero     (out_ch.divisor_zero)
);

// File: dv/tb_top.sv
// Self-checking testbench for the average pooling window unit: stores, windowed averages, config.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PLANE_ROWS     = 256;
  localparam int PLANE_COLS     = 256;
  localparam int PLANE_ENTRIES  = 256 * 256;
  localparam int ITEMS_TARGET   = 1250;
  // Covers a trailing longest average with margin.
  localparam int SETTLE_CYCLES  = 300;
  localparam int HOLD_CYCLES    = 1500;
  // Longest legal quiet stretch: the long hold, one full average and a config settle.
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [8:0] height;
    logic [8:0] width;
    logic [3:0] kern_h;
    logic [3:0] kern_w;
    logic [3:0] step_h;
    logic [3:0] step_w;
    logic [7:0] pad;
    logic       include_pad;
  } pool_cfg_t;

  typedef struct packed {
    apw_pkg::req_type_t                     kind;
    logic [apw_pkg::ROW_W-1:0]              row;
    logic [apw_pkg::COL_W-1:0]              col;
    logic signed [apw_pkg::IN_SAMPLE_W-1:0] sample;
  } pool_req_t;

  typedef struct packed {
    logic signed [apw_pkg::AVG_W-1:0] avg;
    logic [apw_pkg::CNT_W-1:0]        count;
    logic                             zero_div;
  } avg_result_t;

  logic clk = 1'b0;
  logic rst_n;

  apw_in_if  in_bus ();
  apw_out_if out_bus ();
  apw_cfg_if cfg_bus ();

  average_pooling_window_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #6 clk = ~clk;

  pool_req_t   pending_requests[$];
  avg_result_t expected_averages[$];

  logic signed [apw_pkg::IN_SAMPLE_W-1:0] plane_shadow [PLANE_ENTRIES];
  bit                                     stored_mask  [PLANE_ENTRIES];
  pool_cfg_t hw_cfg;    // what the block holds, updated per config transaction
  pool_cfg_t plan_cfg;  // what the stimulus is being generated against

  int requests_outstanding = 0;
  int items_queued = 0;
  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;
  int ready_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int hold_seen = 0;
  int hold_asks = 0;
  int quiet_cycles = 0;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic avg_result_t predict_average(input logic [7:0] orow, input logic [7:0] ocol);
    int r0, c0, r, c, i, j, total, cnt, divisor, h, w;
    avg_result_t res;
    // plane sizes above the store saturate
    h = (int'(hw_cfg.height) > PLANE_ROWS) ? PLANE_ROWS : int'(hw_cfg.height);
    w = (int'(hw_cfg.width) > PLANE_COLS) ? PLANE_COLS : int'(hw_cfg.width);
    r0 = int'(orow) * int'(hw_cfg.step_h) - int'(hw_cfg.pad[7:4]);
    c0 = int'(ocol) * int'(hw_cfg.step_w) - int'(hw_cfg.pad[3:0]);
    total = 0;
    cnt = 0;
    for (i = 0; i < int'(hw_cfg.kern_h); i++) begin
      r = r0 + i;
      if (r < 0 || r >= h) continue;
      for (j = 0; j < int'(hw_cfg.kern_w); j++) begin
        c = c0 + j;
        if (c < 0 || c >= w) continue;
        total += int'(plane_shadow[r * PLANE_COLS + c]);
        cnt++;
      end
    end
    divisor = hw_cfg.include_pad ? int'(hw_cfg.kern_h) * int'(hw_cfg.kern_w) : cnt;
    res.count = apw_pkg::CNT_W'(cnt);
    res.zero_div = (divisor == 0);
    // int division truncates toward zero, as the block does
    res.avg = res.zero_div ? '0 : apw_pkg::AVG_W'(total / divisor);
    return res;
  endfunction

  task automatic apply_request(input logic kind, input logic [7:0] row, input logic [7:0] col,
                               input logic signed [15:0] sample);
    if (kind == apw_pkg::REQ_STORE) begin
      if (int'(row) < int'(hw_cfg.height) && int'(col) < int'(hw_cfg.width))
        plane_shadow[int'(row) * PLANE_COLS + int'(col)] = sample;
    end else begin
      expected_averages.push_back(predict_average(row, col));
    end
  endtask

  task automatic apply_reg(input logic [apw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [apw_pkg::CFG_DATA_W-1:0] val);
    case (apw_pkg::cfg_reg_t'(idx))
      apw_pkg::REG_IN_HEIGHT:         hw_cfg.height = val;
      apw_pkg::REG_IN_WIDTH:          hw_cfg.width = val;
      apw_pkg::REG_KERNEL_H:          hw_cfg.kern_h = val[3:0];
      apw_pkg::REG_KERNEL_W:          hw_cfg.kern_w = val[3:0];
      apw_pkg::REG_STRIDE_H:          hw_cfg.step_h = val[3:0];
      apw_pkg::REG_STRIDE_W:          hw_cfg.step_w = val[3:0];
      apw_pkg::REG_PAD_BEGIN:         hw_cfg.pad = val[7:0];
      apw_pkg::REG_COUNT_INCLUDE_PAD: hw_cfg.include_pad = val[0];
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic queue_store(input int row, input int col, input logic signed [15:0] val);
    pool_req_t req;
    req.kind = apw_pkg::REQ_STORE;
    req.row = 8'(row);
    req.col = 8'(col);
    req.sample = val;
    pending_requests.push_back(req);
    requests_outstanding++;
    if (row < int'(plan_cfg.height) && col < int'(plan_cfg.width)) begin
      stored_mask[row * PLANE_COLS + col] = 1'b1;
      items_queued++;
    end
  endtask

  // Fill any in-plane window position not yet stored, then ask for the average.
  task automatic queue_average(input int orow, input int ocol);
    pool_req_t req;
    int r0, c0, r, c, i, j;
    r0 = orow * int'(plan_cfg.step_h) - int'(plan_cfg.pad[7:4]);
    c0 = ocol * int'(plan_cfg.step_w) - int'(plan_cfg.pad[3:0]);
    for (i = 0; i < int'(plan_cfg.kern_h); i++) begin
      r = r0 + i;
      if (r < 0 || r >= int'(plan_cfg.height)) continue;
      for (j = 0; j < int'(plan_cfg.kern_w); j++) begin
        c = c0 + j;
        if (c < 0 || c >= int'(plan_cfg.width)) continue;
        if (!stored_mask[r * PLANE_COLS + c]) queue_store(r, c, rand_sample());
      end
    end
    req.kind = apw_pkg::REQ_AVERAGE;
    req.row = 8'(orow);
    req.col = 8'(ocol);
    req.sample = 16'($urandom());
    pending_requests.push_back(req);
    requests_outstanding++;
    items_queued++;
  endtask

  task automatic write_reg(input apw_pkg::cfg_reg_t idx,
                           input logic [apw_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic load_config(input pool_cfg_t c);
    write_reg(apw_pkg::REG_IN_HEIGHT, c.height);
    write_reg(apw_pkg::REG_IN_WIDTH, c.width);
    write_reg(apw_pkg::REG_KERNEL_H, apw_pkg::CFG_DATA_W'(c.kern_h));
    write_reg(apw_pkg::REG_KERNEL_W, apw_pkg::CFG_DATA_W'(c.kern_w));
    write_reg(apw_pkg::REG_STRIDE_H, apw_pkg::CFG_DATA_W'(c.step_h));
    write_reg(apw_pkg::REG_STRIDE_W, apw_pkg::CFG_DATA_W'(c.step_w));
    write_reg(apw_pkg::REG_PAD_BEGIN, apw_pkg::CFG_DATA_W'(c.pad));
    write_reg(apw_pkg::REG_COUNT_INCLUDE_PAD, apw_pkg::CFG_DATA_W'(c.include_pad));
    plan_cfg = c;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (requests_outstanding != 0 || expected_averages.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [8:0] pick_extent();
    case ($urandom_range(0, 3))
      0: return 9'd256;
      1: return 9'd1;
      default: return 9'($urandom_range(2, 24));
    endcase
  endfunction

  function automatic logic [3:0] pick_dim();
    if ($urandom_range(0, 2) == 0) return 4'($urandom_range(1, 15));
    return 4'($urandom_range(1, 4));
  endfunction

  function automatic pool_cfg_t random_config();
    pool_cfg_t c;
    c.height = pick_extent();
    c.width = pick_extent();
    c.kern_h = pick_dim();
    c.kern_w = pick_dim();
    c.step_h = pick_dim();
    c.step_w = pick_dim();
    c.pad = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    c.include_pad = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic int max_out_pos(input logic [8:0] extent, input logic [3:0] pad,
                                     input logic [3:0] step);
    int top;
    top = (int'(extent) + int'(pad)) / int'(step);
    return (top > 255) ? 255 : top;
  endfunction

  // Request driver: bursts of transactions separated by random gaps.
  always @(posedge clk) begin
    pool_req_t nxt;
    logic offering;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      offering = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        apply_request(in_bus.req_type, in_bus.row, in_bus.col, in_bus.sample);
        requests_outstanding--;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0 || pending_requests.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_bus.valid <= 1'b0;
        end else begin
          nxt = pending_requests.pop_front();
          in_bus.valid    <= 1'b1;
          in_bus.req_type <= nxt.kind;
          in_bus.row      <= nxt.row;
          in_bus.col      <= nxt.col;
          in_bus.sample   <= nxt.sample;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 31);
            case ($urandom_range(0, 15))
              0: gap_left = $urandom_range(20, 40);
              1, 2, 3, 4, 5: gap_left = 0;
              default: gap_left = $urandom_range(1, 6);
            endcase
          end
        end
      end
    end
  end

  // Result ready: rotating stall modes, plus one long hold on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= 1'($urandom_range(0, 1));
        default: out_bus.ready <= (mode_left % 4 == 0);
      endcase
    end
  end

  // Monitor: track config transactions, check each result against the oldest prediction.
  always @(posedge clk) begin
    avg_result_t want;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) apply_reg(cfg_bus.index, cfg_bus.data);
      if (out_bus.valid && out_bus.ready) begin
        if (expected_averages.size() == 0) begin
          flag_mismatch("result with no average request pending");
        end else begin
          want = expected_averages.pop_front();
          if (out_bus.average !== want.avg)
            flag_mismatch($sformatf("average got %0d want %0d", out_bus.average, want.avg));
          if (out_bus.elements_counted !== want.count)
            flag_mismatch($sformatf("elements_counted got %0d want %0d",
                                    out_bus.elements_counted, want.count));
          if (out_bus.divisor_zero !== want.zero_div)
            flag_mismatch($sformatf("divisor_zero got %0b want %0b",
                                    out_bus.divisor_zero, want.zero_div));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    pool_cfg_t c;
    int phase, budget, pick;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.req_type = apw_pkg::REQ_STORE;
    in_bus.row = '0;
    in_bus.col = '0;
    in_bus.sample = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    hw_cfg = '{apw_pkg::RST_IN_HEIGHT, apw_pkg::RST_IN_WIDTH, apw_pkg::RST_KERNEL,
               apw_pkg::RST_KERNEL, apw_pkg::RST_STRIDE, apw_pkg::RST_STRIDE,
               apw_pkg::RST_PAD, apw_pkg::RST_CIP};
    plan_cfg = hw_cfg;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset config: saturated corners, empty window, truncation of a negative quotient.
    queue_store(0, 0, 16'sh7FFF);
    queue_store(0, 1, 16'sh7FFF);
    queue_store(1, 0, 16'sh7FFF);
    queue_store(1, 1, 16'sh7FFF);
    queue_average(0, 0);
    queue_store(254, 254, 16'sh8000);
    queue_store(254, 255, 16'sh8000);
    queue_store(255, 254, 16'sh8000);
    queue_store(255, 255, 16'sh8000);
    queue_average(127, 127);
    queue_average(200, 3);
    queue_store(1, 1, -16'sd1);
    queue_average(0, 0);
    queue_store(2, 2, -16'sd3);
    queue_store(2, 3, 16'sd0);
    queue_store(3, 2, 16'sd0);
    queue_store(3, 3, 16'sd0);
    queue_average(1, 1);
    wait_idle();

    // Small plane with padding: stores past the edges are dropped.
    load_config('{9'd5, 9'd7, 4'd3, 4'd3, 4'd1, 4'd1, 8'h11, 1'b1});
    queue_store(5, 0, 16'sh1234);
    queue_store(0, 7, 16'sh1234);
    queue_store(255, 255, 16'sh1234);
    queue_average(0, 0);
    queue_average(5, 7);
    wait_idle();

    // Single-entry plane, largest kernel, stride and pad.
    load_config('{9'd1, 9'd1, 4'd15, 4'd15, 4'd15, 4'd15, 8'hFF, 1'b0});
    queue_store(0, 0, 16'sh8000);
    queue_average(0, 0);
    queue_average(1, 1);
    wait_idle();
    write_reg(apw_pkg::REG_COUNT_INCLUDE_PAD, apw_pkg::CFG_DATA_W'(1'b1));
    plan_cfg.include_pad = 1'b1;
    queue_average(0, 0);
    queue_average(1, 1);
    wait_idle();

    phase = 0;
    while (items_queued < ITEMS_TARGET) begin
      c = random_config();
      load_config(c);
      budget = items_queued + $urandom_range(80, 200);
      while (items_queued < budget && items_queued < ITEMS_TARGET) begin
        pick = $urandom_range(0, 99);
        if (pick < 65)
          queue_average($urandom_range(0, max_out_pos(c.height, c.pad[7:4], c.step_h)),
                        $urandom_range(0, max_out_pos(c.width, c.pad[3:0], c.step_w)));
        else if (pick < 80)
          queue_store($urandom_range(0, int'(c.height) - 1), $urandom_range(0, int'(c.width) - 1),
                      rand_sample());
        else if (pick < 92)
          queue_store($urandom_range(0, 255), $urandom_range(0, 255), rand_sample());
        else
          queue_average($urandom_range(0, 255), $urandom_range(0, 255));
      end
      // Stall results long enough for the block to back up onto its input.
      if (phase == 0) hold_asks++;
      wait_idle();
      phase++;
    end

    while (expected_averages.size() != 0) begin
      void'(expected_averages.pop_front());
      flag_mismatch("predicted average never returned");
    end
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
